// File: src/tcfq_pkg.sv
// Shared constants and types for the two-class oldest-first queue.
package tcfq_pkg;

  localparam int QueueDepth = 1024;
  localparam int IdxW       = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);
  localparam int IdW        = 31;
  localparam int StampW     = 32;

  typedef enum logic [1:0] {
    KIND_ENQUEUE  = 2'd0,
    KIND_TAKE_ANY = 2'd1,
    KIND_TAKE_DOG = 2'd2,
    KIND_TAKE_CAT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_ENQUEUED = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_RETURNED = 2'd2,
    STATUS_NONE     = 2'd3
  } status_e;

  typedef struct packed {
    logic [StampW-1:0] stamp;
    logic [IdW-1:0]    id;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t entry;
  } q_ctrl_t;

  typedef struct packed {
    logic   full;
    logic   empty;
    entry_t head;
  } q_stat_t;

endpackage

// File: src/tcfq_queue.sv
// One class FIFO with a prefetched head entry read from its storage array.
module tcfq_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tcfq_pkg::q_ctrl_t ctrl_i,
  output tcfq_pkg::q_stat_t stat_o
);
  import tcfq_pkg::*;

  entry_t          mem [QueueDepth];
  entry_t          head_entry_q;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic            full, empty;

  assign full  = (count_q == CntW'(QueueDepth));
  assign empty = (count_q == '0);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctrl_i.pop) begin
      head_d  = (head_q == IdxW'(QueueDepth - 1)) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
    if (ctrl_i.push) begin
      tail_d  = (tail_q == IdxW'(QueueDepth - 1)) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[tail_q] <= ctrl_i.entry;
    end
  end

  // prefetch next head; forward a write into an empty queue
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && (tail_q == head_d)) begin
      head_entry_q <= ctrl_i.entry;
    end else begin
      head_entry_q <= mem[head_d];
    end
  end

  assign stat_o.full  = full;
  assign stat_o.empty = empty;
  assign stat_o.head  = head_entry_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("queue count beyond depth");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> !full)
    else $error("push into full queue");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> !empty)
    else $error("pop from empty queue");

  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.push && !ctrl_i.pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("push did not raise count");

endmodule

// File: src/two_class_fifo_oldest_first.sv
// Top level: two class FIFOs with oldest-first dequeue by arrival stamp.
//
//  channel   handshake               payload
//  request   start_i (busy_o low)    kind_i, animal_id_i, species_i
//  result    done_o strobe           status_o, out_id_o, out_species_o
//
//  One request per cycle; its result appears on the cycle after acceptance.
//  Rate is set by the registered head prefetch of each queue's storage array.
//  busy_o is always low; no clearing pass after reset, counts start at zero.
//  The receiver cannot stall; each result is shown for exactly one cycle.
module two_class_fifo_oldest_first (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [1:0]               kind_i,
  input  logic [tcfq_pkg::IdW-1:0] animal_id_i,
  input  logic                     species_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic [tcfq_pkg::IdW-1:0] out_id_o,
  output logic                     out_species_o
);
  import tcfq_pkg::*;

  kind_e             kind;
  q_ctrl_t           cat_ctrl, dog_ctrl;
  q_stat_t           cat_stat, dog_stat;
  logic [StampW-1:0] arrival_q, arrival_d;
  logic [StampW-1:0] stamp_diff;
  logic              pick_cat, pick_dog;
  status_e           status_d, status_q;
  logic [IdW-1:0]    out_id_d, out_id_q;
  logic              out_species_d, out_species_q;
  logic              done_q;

  assign kind       = kind_e'(kind_i);
  assign stamp_diff = cat_stat.head.stamp - dog_stat.head.stamp;

  always_comb begin
    pick_cat = 1'b0;
    pick_dog = 1'b0;
    case (kind)
      KIND_TAKE_CAT: pick_cat = !cat_stat.empty;
      KIND_TAKE_DOG: pick_dog = !dog_stat.empty;
      KIND_TAKE_ANY: begin
        if (!cat_stat.empty && !dog_stat.empty) begin
          pick_cat = stamp_diff[StampW-1];
          pick_dog = !stamp_diff[StampW-1];
        end else begin
          pick_cat = !cat_stat.empty;
          pick_dog = !dog_stat.empty;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cat_ctrl.push        = 1'b0;
    cat_ctrl.pop         = 1'b0;
    cat_ctrl.entry.stamp = arrival_q;
    cat_ctrl.entry.id    = animal_id_i;
    dog_ctrl             = cat_ctrl;
    arrival_d            = arrival_q;
    status_d             = STATUS_NONE;
    out_id_d             = '0;
    out_species_d        = 1'b0;
    if (kind == KIND_ENQUEUE) begin
      if (species_i ? dog_stat.full : cat_stat.full) begin
        status_d = STATUS_FULL;
      end else begin
        status_d      = STATUS_ENQUEUED;
        cat_ctrl.push = start_i && !species_i;
        dog_ctrl.push = start_i && species_i;
        if (start_i) begin
          arrival_d = arrival_q + 1'b1;
        end
      end
    end else if (pick_cat) begin
      status_d     = STATUS_RETURNED;
      out_id_d     = cat_stat.head.id;
      cat_ctrl.pop = start_i;
    end else if (pick_dog) begin
      status_d      = STATUS_RETURNED;
      out_id_d      = dog_stat.head.id;
      out_species_d = 1'b1;
      dog_ctrl.pop  = start_i;
    end
  end

  tcfq_queue u_cat_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cat_ctrl),
    .stat_o (cat_stat)
  );

  tcfq_queue u_dog_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (dog_ctrl),
    .stat_o (dog_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arrival_q <= '0;
      done_q    <= 1'b0;
    end else begin
      arrival_q <= arrival_d;
      done_q    <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      status_q      <= status_d;
      out_id_q      <= out_id_d;
      out_species_q <= out_species_d;
    end
  end

  assign busy_o        = 1'b0;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign out_id_o      = out_id_q;
  assign out_species_o = out_species_q;

  a_one_queue_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cat_ctrl.push, cat_ctrl.pop, dog_ctrl.push, dog_ctrl.pop}) <= 1)
    else $error("more than one queue operation in a cycle");

  a_stamp_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cat_ctrl.push || dog_ctrl.push) |=> arrival_q == $past(arrival_q) + 1'b1)
    else $error("arrival stamp did not advance on enqueue");

  a_returned_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && status_d == STATUS_RETURNED) |-> (cat_ctrl.pop || dog_ctrl.pop))
    else $error("entry returned without a pop");

endmodule

// File: dv/tb_two_class_fifo_oldest_first.sv
// Testbench for two_class_fifo_oldest_first: stimulus, predictor and result checks.
`timescale 1ns / 1ps

module tb_two_class_fifo_oldest_first;
  import tcfq_pkg::*;

  localparam int QuietLimit = 1000;

  typedef struct {
    status_e        status;
    logic [IdW-1:0] id;
    logic           species;
  } outcome_t;

  class shelter_scoreboard;
    entry_t            cat_line[$];
    entry_t            dog_line[$];
    logic [StampW-1:0] next_stamp;
    outcome_t          due[$];
    int                errors;

    function new();
      next_stamp = '0;
      errors = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function int level(logic species);
      return species ? dog_line.size() : cat_line.size();
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void note_request(kind_e kind, logic [IdW-1:0] id, logic species);
      outcome_t          o;
      entry_t            e;
      logic [StampW-1:0] gap;
      int                pick;
      o.status = STATUS_NONE;
      o.id = '0;
      o.species = 1'b0;
      pick = -1;
      case (kind)
        KIND_ENQUEUE: begin
          if (level(species) >= QueueDepth) begin
            o.status = STATUS_FULL;
          end else begin
            e.stamp = next_stamp;
            e.id = id;
            if (species) dog_line.push_back(e);
            else cat_line.push_back(e);
            next_stamp = next_stamp + 1'b1;
            o.status = STATUS_ENQUEUED;
          end
        end
        KIND_TAKE_DOG: if (dog_line.size() != 0) pick = 1;
        KIND_TAKE_CAT: if (cat_line.size() != 0) pick = 0;
        default: begin
          if (cat_line.size() != 0 && dog_line.size() != 0) begin
            gap = cat_line[0].stamp - dog_line[0].stamp;
            pick = gap[StampW-1] ? 0 : 1;
          end else if (cat_line.size() != 0) begin
            pick = 0;
          end else if (dog_line.size() != 0) begin
            pick = 1;
          end
        end
      endcase
      if (pick == 0) begin
        e = cat_line.pop_front();
        o.status = STATUS_RETURNED;
        o.id = e.id;
      end else if (pick == 1) begin
        e = dog_line.pop_front();
        o.status = STATUS_RETURNED;
        o.id = e.id;
        o.species = 1'b1;
      end
      due.push_back(o);
    endfunction

    function void check_result(logic [1:0] status, logic [IdW-1:0] id, logic species);
      outcome_t o;
      if (due.size() == 0) begin
        flag($sformatf("unexpected result: status=%0d id=%h species=%0d",
                       status, id, species));
        return;
      end
      o = due.pop_front();
      if (status !== o.status || id !== o.id || species !== o.species) begin
        flag($sformatf({"mismatch: expected status=%0d id=%h species=%0d,",
                        " got status=%0d id=%h species=%0d"},
                       o.status, o.id, o.species, status, id, species));
      end
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           start_i;
  logic           busy_o;
  logic [1:0]     kind_i;
  logic [IdW-1:0] animal_id_i;
  logic           species_i;
  logic           done_o;
  logic [1:0]     status_o;
  logic [IdW-1:0] out_id_o;
  logic           out_species_o;

  shelter_scoreboard shelter = new();
  int                idle_pct;
  int                quiet_cycles;

  two_class_fifo_oldest_first u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .kind_i        (kind_i),
    .animal_id_i   (animal_id_i),
    .species_i     (species_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .out_id_o      (out_id_o),
    .out_species_o (out_species_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) shelter.check_result(status_o, out_id_o, out_species_o);
      if ((start_i && !busy_o) || done_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("two_class_fifo_oldest_first test failed");
        $finish;
      end
    end
  end

  task automatic send(kind_e kind, logic [IdW-1:0] id, logic species);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i     <= 1'b1;
    kind_i      <= kind;
    animal_id_i <= id;
    species_i   <= species;
    do @(posedge clk_i); while (busy_o);
    shelter.note_request(kind, id, species);
  endtask

  task automatic send_random(int enq_pct);
    logic [IdW-1:0] id;
    logic           species;
    int             r;
    id = IdW'($urandom());
    species = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < enq_pct) send(KIND_ENQUEUE, id, species);
    else if (r < enq_pct + (100 - enq_pct) / 2) send(KIND_TAKE_ANY, id, species);
    else if ($urandom_range(0, 1) == 1) send(KIND_TAKE_DOG, id, species);
    else send(KIND_TAKE_CAT, id, species);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (shelter.pending() != 0) @(posedge clk_i);
  endtask

  task automatic random_phase(int pct, int chunks);
    int enq_pct;
    idle_pct = pct;
    repeat (chunks) begin
      enq_pct = $urandom_range(20, 80);
      repeat (25) send_random(enq_pct);
    end
    drain_results();
  endtask

  initial begin
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    kind_i       = KIND_ENQUEUE;
    animal_id_i  = '0;
    species_i    = 1'b0;
    idle_pct     = 0;
    quiet_cycles = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    send(KIND_TAKE_ANY, '1, 1'b1);
    send(KIND_TAKE_DOG, '0, 1'b0);
    send(KIND_TAKE_CAT, '1, 1'b1);
    send(KIND_ENQUEUE, '0, 1'b0);
    send(KIND_ENQUEUE, '1, 1'b1);
    send(KIND_ENQUEUE, '1, 1'b0);
    send(KIND_ENQUEUE, '0, 1'b1);
    send(KIND_ENQUEUE, 31'h2AAA_AAAA, 1'b0);
    send(KIND_ENQUEUE, 31'h5555_5555, 1'b1);
    send(KIND_TAKE_ANY, '0, 1'b0);
    send(KIND_TAKE_ANY, '1, 1'b1);
    send(KIND_TAKE_DOG, '1, 1'b0);
    send(KIND_TAKE_CAT, '0, 1'b1);
    send(KIND_TAKE_ANY, '0, 1'b1);
    send(KIND_TAKE_ANY, '1, 1'b0);
    send(KIND_TAKE_ANY, '0, 1'b0);
    send(KIND_TAKE_DOG, '0, 1'b1);
    send(KIND_TAKE_CAT, '1, 1'b0);
    drain_results();

    // fill the cat queue past full, then take from both classes
    idle_pct = 15;
    while (shelter.level(1'b0) < QueueDepth) begin
      send(KIND_ENQUEUE, IdW'($urandom()), 1'b0);
    end
    repeat (3) send(KIND_ENQUEUE, IdW'($urandom()), 1'b0);
    send(KIND_TAKE_DOG, IdW'($urandom()), 1'b1);
    send(KIND_TAKE_ANY, IdW'($urandom()), 1'b0);
    send(KIND_ENQUEUE, IdW'($urandom()), 1'b1);
    send(KIND_TAKE_ANY, IdW'($urandom()), 1'b1);
    drain_results();

    random_phase(0, 1);
    random_phase(64, 1);
    random_phase(0, 1);
    random_phase(15, 1);

    repeat (4) @(posedge clk_i);
    if (shelter.pending() != 0) begin
      shelter.flag($sformatf("%0d results never arrived", shelter.pending()));
    end
    if (shelter.errors == 0) begin
      $display("two_class_fifo_oldest_first test passed");
    end else begin
      $display("two_class_fifo_oldest_first test failed");
    end
    $finish;
  end

endmodule
